@@ src/irm_pkg.sv @@
// irm_pkg: shared constants, codes and controller/datapath interface types
// for the interval range map. No dependencies.
package irm_pkg;

   // default sizes
   localparam int DEF_TABLE_DEPTH = 64;
   localparam int DEF_KEY_BITS    = 16;
   localparam int DEF_VALUE_BITS  = 8;

   // command codes
   localparam logic CMD_ASSIGN = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // response status codes
   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic start;    // latch request, reset scan
      logic read;     // issue table read, advance index
      logic step;     // consume the entry just read
      logic ins_b;    // resolve begin breakpoint
      logic ins_e;    // resolve end breakpoint
      logic finish;   // load response, commit table
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty_range;
      logic is_lookup;
      logic table_empty;
      logic last_entry;
      logic key_ge_b;
      logic key_gt_e;
      logic begin_done;
      logic end_done;
      logic rsp_busy;
   } stat_type;

endpackage

@@ src/irm_ctrl.sv @@
// irm_ctrl: sequencing state machine for the interval range map scan.
// Depends on irm_pkg.
module irm_ctrl
   import irm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHK  = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_TAIL = 3'd4;
   localparam logic [2:0] S_INSB = 3'd5;
   localparam logic [2:0] S_INSE = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       ret_tail_ff, ret_tail_in;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      ret_tail_in = ret_tail_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.empty_range) state_in = S_FIN;
            else if (stat.table_empty) state_in = S_TAIL;
            else state_in = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            ret_tail_in = 1'b0;
            if (!stat.is_lookup && !stat.begin_done && stat.key_ge_b) begin
               state_in = S_INSB;
            end else if (!stat.end_done && stat.key_gt_e) begin
               state_in = S_INSE;
            end else begin
               cmd.step = 1'b1;
               state_in = stat.last_entry ? S_TAIL : S_READ;
            end
         end
         S_TAIL: begin
            ret_tail_in = 1'b1;
            if (!stat.is_lookup && !stat.begin_done) state_in = S_INSB;
            else if (!stat.end_done) state_in = S_INSE;
            else state_in = S_FIN;
         end
         S_INSB: begin
            cmd.ins_b = 1'b1;
            state_in  = ret_tail_ff ? S_TAIL : S_EVAL;
         end
         S_INSE: begin
            cmd.ins_e = 1'b1;
            state_in  = ret_tail_ff ? S_TAIL : S_EVAL;
         end
         S_FIN: begin
            if (!stat.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ret_tail_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ret_tail_ff <= ret_tail_in;
      end
   end

endmodule

@@ src/irm_dp.sv @@
// irm_dp: breakpoint table (two banks), scan registers and response register.
// Depends on irm_pkg; driven by irm_ctrl.
module irm_dp
   import irm_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = DEF_KEY_BITS,
   parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic                  req_command,
   input  logic [KEY_BITS-1:0]   req_range_start,
   input  logic [KEY_BITS-1:0]   req_range_stop,
   input  logic [VALUE_BITS-1:0] req_new_value,
   input  logic [KEY_BITS-1:0]   req_probe_key,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_found_value,
   output logic [1:0]            rsp_status,
   input  logic                  csr_write_enable,
   input  logic [VALUE_BITS-1:0] csr_write_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int MW = $clog2(2 * TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int NW = $clog2(TABLE_DEPTH + 3);

   // two banks: live one read, the other rebuilt
   logic [KEY_BITS-1:0]   key_mem [2*TABLE_DEPTH];
   logic [VALUE_BITS-1:0] val_mem [2*TABLE_DEPTH];

   logic [VALUE_BITS-1:0] base_ff;
   logic                  bank_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         idx_ff;
   logic [NW-1:0]         n_ff;
   logic                  lookup_ff, empty_ff, bdone_ff, edone_ff;
   logic [KEY_BITS-1:0]   b_ff, e_ff;
   logic [VALUE_BITS-1:0] v_ff, cur_v_ff, end_v_ff;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [VALUE_BITS-1:0] rd_val_ff;
   logic                  rsp_valid_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [1:0]            rsp_status_ff;

   logic                  copy, wr_en, overflow, n_room;
   logic [MW-1:0]         rd_addr, wr_addr;
   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_val;

   // write selection
   always_comb begin
      copy    = !lookup_ff && (!bdone_ff || edone_ff);
      n_room  = n_ff < NW'(TABLE_DEPTH);
      wr_key  = rd_key_ff;
      wr_val  = rd_val_ff;
      wr_en   = 1'b0;
      if (cmd.ins_b) begin
         wr_key = b_ff;
         wr_val = v_ff;
         wr_en  = cur_v_ff != v_ff;
      end else if (cmd.ins_e) begin
         wr_key = e_ff;
         wr_val = cur_v_ff;
         wr_en  = !lookup_ff && (cur_v_ff != v_ff);
      end else if (cmd.step) begin
         wr_en  = copy;
      end
      overflow = n_ff > NW'(TABLE_DEPTH);
      rd_addr  = MW'(idx_ff[AW-1:0]) + (bank_ff ? MW'(TABLE_DEPTH) : '0);
      wr_addr  = MW'(n_ff[AW-1:0]) + (bank_ff ? '0 : MW'(TABLE_DEPTH));
   end

   // table memory
   always_ff @(posedge clock) begin
      if (wr_en && n_room) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
      if (cmd.read) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_val_ff <= val_mem[rd_addr];
      end
   end

   // request and scan registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         lookup_ff <= req_command == CMD_LOOKUP;
         empty_ff  <= (req_command == CMD_ASSIGN) && !(req_range_start < req_range_stop);
         b_ff      <= req_range_start;
         e_ff      <= (req_command == CMD_LOOKUP) ? req_probe_key : req_range_stop;
         v_ff      <= req_new_value;
         cur_v_ff  <= base_ff;
         end_v_ff  <= base_ff;
         bdone_ff  <= req_command == CMD_LOOKUP;
         edone_ff  <= 1'b0;
      end else begin
         if (cmd.step) cur_v_ff <= rd_val_ff;
         if (cmd.ins_b) bdone_ff <= 1'b1;
         if (cmd.ins_e) begin
            edone_ff <= 1'b1;
            end_v_ff <= cur_v_ff;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         bank_ff       <= 1'b0;
         count_ff      <= '0;
         idx_ff        <= '0;
         n_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_value_ff  <= '0;
         rsp_status_ff <= STAT_DONE;
      end else begin
         if (csr_write_enable) base_ff <= csr_write_data;
         if (cmd.start) begin
            idx_ff <= '0;
            n_ff   <= '0;
         end else begin
            if (cmd.read) idx_ff <= idx_ff + 1'b1;
            if (wr_en) n_ff <= n_ff + 1'b1;
         end
         if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            rsp_value_ff <= lookup_ff ? end_v_ff : '0;
            if (lookup_ff) rsp_status_ff <= STAT_DONE;
            else if (empty_ff) rsp_status_ff <= STAT_EMPTY;
            else if (overflow) rsp_status_ff <= STAT_FULL;
            else begin
               rsp_status_ff <= STAT_DONE;
               bank_ff       <= !bank_ff;
               count_ff      <= CW'(n_ff);
            end
         end
      end
   end

   // status to controller
   always_comb begin
      stat.empty_range = empty_ff;
      stat.is_lookup   = lookup_ff;
      stat.table_empty = count_ff == '0;
      stat.last_entry  = idx_ff == count_ff;
      stat.key_ge_b    = rd_key_ff >= b_ff;
      stat.key_gt_e    = rd_key_ff > e_ff;
      stat.begin_done  = bdone_ff;
      stat.end_done    = edone_ff;
      stat.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

@@ src/interval_range_map.sv @@
// Interval range map: sorted breakpoint table, range assign and key lookup.
// Each stored breakpoint is read and then evaluated, one entry at a time, plus
// a resolve step per range boundary (two on assign, one on lookup).
// An empty range skips the scan. One transaction at a time; the next request
// is accepted once the response is loaded; a held response stalls it.
// Reset empties the table and clears base_value; table RAM is not cleared.
module interval_range_map
   import irm_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = DEF_KEY_BITS,
   parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic [KEY_BITS-1:0]   req_range_start,
   input  logic [KEY_BITS-1:0]   req_range_stop,
   input  logic [VALUE_BITS-1:0] req_new_value,
   input  logic [KEY_BITS-1:0]   req_probe_key,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_found_value,
   output logic [1:0]            rsp_status,
   input  logic                  csr_write_enable,
   input  logic [VALUE_BITS-1:0] csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   irm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   irm_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_command      (req_command),
      .req_range_start  (req_range_start),
      .req_range_stop   (req_range_stop),
      .req_new_value    (req_new_value),
      .req_probe_key    (req_probe_key),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found_value  (rsp_found_value),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

`ifndef SYNTHESIS
   // a transaction in flight blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while scan in progress");

   // a pending response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_value)
         && $stable(rsp_status))
      else $error("response changed before it was taken");

   // a response with a nonzero value never reports an error status
   a_lookup_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found_value != '0 |-> rsp_status == STAT_DONE)
      else $error("nonzero value with error status");
`endif

endmodule
